FILE: src/sfrc_pkg.sv
// ----------------------------------------------------------------------------
// sfrc_pkg
// Shared types and constants for the serial frame receiver with checksum.
// ----------------------------------------------------------------------------
package sfrc_pkg;

    localparam logic [7:0]  SYNC0_BYTE   = 8'h55;
    localparam logic [7:0]  SYNC1_BYTE   = 8'hAA;
    localparam logic [7:0]  MIN_LENGTH   = 8'd2;
    localparam logic [15:0] TICK_MAX     = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RST  = 16'd100;

    // parse positions (0 = hunting)
    localparam logic [8:0]  POS_HUNT     = 9'd0;
    localparam logic [8:0]  POS_SYNC0    = 9'd1;
    localparam logic [8:0]  POS_SYNC1    = 9'd2;
    localparam logic [8:0]  POS_LENGTH   = 9'd3;
    localparam logic [8:0]  POS_ADDRESS  = 9'd4;
    localparam logic [8:0]  POS_COMMAND  = 9'd5;
    localparam logic [8:0]  POS_OFFSET   = 9'd6;
    localparam logic [8:0]  POS_DATA0    = 9'd7;
    localparam logic [8:0]  POS_TAIL     = 9'd5;   // last position is length + 5

    localparam logic        MODE_BYTE    = 1'b0;
    localparam logic        MODE_TICK    = 1'b1;

    localparam logic        REG_TIMEOUT  = 1'b0;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [15:0] checksum_received;
        logic [7:0]  register_offset;
        logic [7:0]  command_mode;
        logic [7:0]  dest_address;
        logic [7:0]  frame_length;
        logic [7:0]  data_index;
        logic [7:0]  data_byte;
        t_kind       kind;
    } t_result;

endpackage

FILE: src/sfrc_parser.sv
// ----------------------------------------------------------------------------
// sfrc_parser
// Per-beat frame parser: header sync, timeout, running sum and result build.
// ----------------------------------------------------------------------------
module sfrc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_mode,
    input  logic [7:0]        i_byte,
    input  logic [15:0]       i_timeout,
    output logic              o_res_valid,
    output sfrc_pkg::t_result o_res
);
    import sfrc_pkg::*;

    logic [8:0]  r_pos,     n_pos;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] r_sum,     n_sum;
    logic [7:0]  r_len,     n_len;
    logic [7:0]  r_addr,    n_addr;
    logic [7:0]  r_cmd,     n_cmd;
    logic [7:0]  r_ofs,     n_ofs;
    logic [7:0]  r_csum_lo, n_csum_lo;

    logic        timed_out;
    logic [8:0]  pos_inc;
    logic [8:0]  data_pos;
    logic [8:0]  ndata;
    logic [15:0] got;
    logic        res_valid;
    t_result     res;

    always_comb begin
        timed_out = (r_elapsed >= i_timeout);
        pos_inc   = (timed_out ? POS_HUNT : r_pos) + 9'd1;
        data_pos  = pos_inc - POS_DATA0;
        ndata     = {1'b0, r_len} - {1'b0, MIN_LENGTH};
        got       = {i_byte, r_csum_lo};

        n_pos     = r_pos;
        n_elapsed = r_elapsed;
        n_sum     = r_sum;
        n_len     = r_len;
        n_addr    = r_addr;
        n_cmd     = r_cmd;
        n_ofs     = r_ofs;
        n_csum_lo = r_csum_lo;

        res_valid             = 1'b0;
        res.kind              = KIND_DATA;
        res.data_byte         = 8'd0;
        res.data_index        = 8'd0;
        res.frame_length      = r_len;
        res.dest_address      = r_addr;
        res.command_mode      = r_cmd;
        res.register_offset   = r_ofs;
        res.checksum_received = 16'd0;

        if (i_mode == MODE_TICK) begin
            if (r_elapsed != TICK_MAX) begin
                n_elapsed = r_elapsed + 16'd1;
            end
        end else begin
            n_pos = pos_inc;
            case (pos_inc)
                POS_SYNC0: begin
                    if (i_byte != SYNC0_BYTE) begin
                        n_pos = POS_HUNT;
                    end else begin
                        n_elapsed = 16'd0;
                    end
                end
                POS_SYNC1: begin
                    if (i_byte != SYNC1_BYTE) begin
                        n_pos = POS_HUNT;
                    end
                end
                POS_LENGTH: begin
                    if (i_byte < MIN_LENGTH) begin
                        n_pos = POS_HUNT;
                    end else begin
                        n_len = i_byte;
                        n_sum = {8'd0, i_byte};
                    end
                end
                POS_ADDRESS: begin
                    n_addr = i_byte;
                    n_sum  = r_sum + {8'd0, i_byte};
                end
                POS_COMMAND: begin
                    n_cmd = i_byte;
                    n_sum = r_sum + {8'd0, i_byte};
                end
                POS_OFFSET: begin
                    n_ofs = i_byte;
                    n_sum = r_sum + {8'd0, i_byte};
                end
                default: begin
                    if (data_pos < ndata) begin
                        n_sum          = r_sum + {8'd0, i_byte};
                        res_valid      = 1'b1;
                        res.data_byte  = i_byte;
                        res.data_index = data_pos[7:0];
                    end else if (data_pos == ndata) begin
                        n_csum_lo = i_byte;
                    end else begin
                        n_pos                 = POS_HUNT;
                        res_valid             = 1'b1;
                        res.kind              = (got == ~r_sum) ? KIND_GOOD : KIND_BAD;
                        res.checksum_received = got;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_HUNT;
            r_elapsed <= TICK_MAX;
            r_sum     <= 16'd0;
            r_len     <= 8'd0;
            r_addr    <= 8'd0;
            r_cmd     <= 8'd0;
            r_ofs     <= 8'd0;
            r_csum_lo <= 8'd0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
            r_sum     <= n_sum;
            r_len     <= n_len;
            r_addr    <= n_addr;
            r_cmd     <= n_cmd;
            r_ofs     <= n_ofs;
            r_csum_lo <= n_csum_lo;
        end
    end

    assign o_res_valid = i_accept && res_valid;
    assign o_res       = res;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos < POS_LENGTH) || (r_pos <= ({1'b0, r_len} + POS_TAIL)))
        else $error("parse position past end of frame");

    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (res.kind != KIND_DATA)) |=> (r_pos == POS_HUNT))
        else $error("parser did not return to hunting after frame end");

    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos >= POS_LENGTH) |-> (r_len >= MIN_LENGTH))
        else $error("frame in progress with short length");

    a_tick_no_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_mode == MODE_TICK) |-> !o_res_valid)
        else $error("tick beat produced a result");
`endif

endmodule

FILE: src/sfrc_outbuf.sv
// ----------------------------------------------------------------------------
// sfrc_outbuf
// Output register with one skid entry; decouples input ready from output stall.
// ----------------------------------------------------------------------------
module sfrc_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sfrc_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    output sfrc_pkg::t_result o_res,
    input  logic              i_ready
);
    import sfrc_pkg::*;

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;
    logic    drain;

    always_comb begin
        drain        = r_out_valid && i_ready;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;

        if (drain) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid  = 1'b0;
            end
        end

        if (i_valid) begin
            if (!n_out_valid) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost under stall");

    a_skid_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out == $past(r_skid)))
        else $error("skid entry not moved to output");
`endif

endmodule

FILE: src/serial_frame_receiver_checksum_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_checksum_unit
// Deframes 0x55 0xAA serial packets, streams payload bytes, checks the
// inverted 16-bit sum and reports frame good or checksum mismatch.
// ----------------------------------------------------------------------------
// Takes one beat per clock (a received byte or a timer tick) with no gaps
// needed between beats. Each beat is parsed in the cycle it is accepted and
// any result is registered in the output register, or in the one-entry skid
// buffer behind it when that is full, before it reaches the master side, so
// s_axis_tready stays high and input stalls only when both are full.
// Ticks never produce a result. The timeout register sits at byte address 0.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checksum_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] data_byte, [15:8] data_index,
                                        // [23:16] frame_length, [31:24] dest_address,
                                        // [39:32] command_mode, [47:40] register_offset,
                                        // [63:48] checksum_received
    output logic [1:0]  m_axis_tuser,   // [1:0] kind

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfrc_pkg::*;

    logic [15:0] r_timeout;
    logic        cfg_wr;
    logic        in_accept;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (cfg_wr && (paddr[2] == REG_TIMEOUT)) begin
            r_timeout <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, r_timeout} : 32'd0;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    sfrc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_mode      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_timeout   (r_timeout),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sfrc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_res.checksum_received, out_res.register_offset,
                           out_res.command_mode, out_res.dest_address,
                           out_res.frame_length, out_res.data_index,
                           out_res.data_byte};
    assign m_axis_tuser = out_res.kind;

endmodule
